// ===== hdl/qrvi_pkg.sv =====
// Shared types, constants and codeword functions for the QR version-info decoder.
package qrvi_pkg;

    // Code geometry: 34 codewords of 18 bits, versions 7 to 40.
    localparam int VI_COUNT     = 34;
    localparam int VI_BITS      = 18;
    localparam int VI_FIRST     = 7;
    localparam int VER_W        = 6;
    localparam int DIST_W       = 5;
    localparam int MAXERR_W     = 4;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 16;

    // BCH(18,6) generator polynomial, aligned to the word width.
    localparam logic [VI_BITS-1:0] VI_GEN = 18'h01F25;

    // Reset value of the distance limit.
    localparam logic [MAXERR_W-1:0] MAX_ERRORS_RST = 4'd3;

    // Start distance that any real distance beats.
    localparam logic [DIST_W-1:0] DIST_NONE = DIST_W'(VI_BITS + 1);

    // Running result that travels down the chain next to the sampled word.
    typedef struct packed {
        logic [VI_BITS-1:0] word;
        logic [VER_W-1:0]   version;
        logic [DIST_W-1:0]  distance;
    } t_link;

    // Result that waits at the output.
    typedef struct packed {
        logic               found;
        logic [VER_W-1:0]   version;
        logic [DIST_W-1:0]  distance;
    } t_result;

    // Builds the 18-bit codeword: version on top, BCH remainder below.
    function automatic logic [VI_BITS-1:0] vi_codeword(input logic [VER_W-1:0] ver);
        logic [VI_BITS-1:0] rem;
        rem = {ver, 12'h000};
        for (int b = VI_BITS - 1; b >= 12; b--) begin
            if (rem[b]) begin
                rem = rem ^ (VI_GEN << (b - 12));
            end
        end
        return {ver, rem[11:0]};
    endfunction

    // Counts set bits of an 18-bit difference word.
    function automatic logic [DIST_W-1:0] vi_popcount(input logic [VI_BITS-1:0] x);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int i = 0; i < VI_BITS; i++) begin
            n = n + DIST_W'(x[i]);
        end
        return n;
    endfunction

endpackage

// ===== hdl/qrvi_cell.sv =====
// One compare cell: matches the word against a single fixed codeword.
module qrvi_cell #(
    parameter int VERSION = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  qrvi_pkg::t_link i_link,
    output logic           o_valid,
    output qrvi_pkg::t_link o_link
);
    import qrvi_pkg::*;

    localparam logic [VER_W-1:0]   CODE_VER = VER_W'(VERSION);
    localparam logic [VI_BITS-1:0] CODE     = vi_codeword(CODE_VER);

    logic              r_valid;
    t_link             r_link;
    t_link             n_link;
    logic [DIST_W-1:0] distance;

    // Distance to this cell's codeword; a strictly smaller one takes over.
    always_comb begin
        distance = vi_popcount(i_link.word ^ CODE);
        n_link   = i_link;
        if (distance < i_link.distance) begin
            n_link.version  = CODE_VER;
            n_link.distance = distance;
        end
    end

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload of the stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_link <= n_link;
        end
    end

    assign o_valid = r_valid;
    assign o_link  = r_link;

endmodule

// ===== hdl/qrvi_out_buf.sv =====
// Two-entry output buffer that lets the cell chain run while a result waits.
module qrvi_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qrvi_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output qrvi_pkg::t_result o_result
);
    import qrvi_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop = r_main_valid && i_ready;

    // Occupancy of the two entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // Data of the two entries.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

endmodule

// ===== hdl/qr_version_info_nearest_decode.sv =====
// Top level of the QR version-information nearest-codeword decoder.
//
// Each request on the slave stream carries one sampled 18-bit version word. The word
// walks down a row of 34 compare cells, one per version 7 to 40, one cell per cycle
// while s_tready is high; each cell counts the bits that differ from its fixed codeword
// and keeps the first nearest codeword seen so far. One word is accepted every cycle
// while s_tready is high, and a result leaves the output buffer when the master side
// is ready. The found flag compares the distance with max_errors (reset 3), written
// through the cfg channel; the user must write it only while no word is in flight, which
// the block does not enforce. A two-entry output buffer holds results while the master
// side stalls; s_tready drops only when both entries are full.
module qr_version_info_nearest_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: [17:0] version_word, rest zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [qrvi_pkg::S_TDATA_W-1:0] s_tdata,
    // Master stream: [5:0] version, [10:6] bit_distance, rest zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [qrvi_pkg::M_TDATA_W-1:0] m_tdata,
    // Master stream user: [0] found.
    output logic        m_tuser,
    // Configuration: [3:0] max_errors.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [qrvi_pkg::MAXERR_W-1:0] i_cfg_data
);
    import qrvi_pkg::*;

    logic [MAXERR_W-1:0] r_max_errors;
    logic                en;
    logic                buf_full;
    logic                chain_valid [VI_COUNT+1];
    t_link               chain_link  [VI_COUNT+1];
    t_result             last_result;
    t_result             out_result;

    // Distance limit register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_errors <= MAX_ERRORS_RST;
        end else if (i_cfg_valid) begin
            r_max_errors <= i_cfg_data;
        end
    end

    // The whole chain moves unless the output buffer is full.
    assign en       = !buf_full;
    assign s_tready = en;

    // Chain head: fresh word with no candidate yet.
    assign chain_valid[0]         = s_tvalid;
    assign chain_link[0].word     = s_tdata[VI_BITS-1:0];
    assign chain_link[0].version  = VER_W'(VI_FIRST);
    assign chain_link[0].distance = DIST_NONE;

    // Row of compare cells, one per version.
    for (genvar g = 0; g < VI_COUNT; g++) begin : g_cell
        qrvi_cell #(
            .VERSION (g + VI_FIRST)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[g]),
            .i_link  (chain_link[g]),
            .o_valid (chain_valid[g+1]),
            .o_link  (chain_link[g+1])
        );
    end

    // Final verdict against the configured limit.
    always_comb begin
        last_result.found    = ({1'b0, r_max_errors} >= chain_link[VI_COUNT].distance);
        last_result.version  = chain_link[VI_COUNT].version;
        last_result.distance = chain_link[VI_COUNT].distance;
    end

    qrvi_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (en && chain_valid[VI_COUNT]),
        .i_result (last_result),
        .o_full   (buf_full),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (out_result)
    );

    assign m_tdata = {(M_TDATA_W - VER_W - DIST_W)'(0), out_result.distance,
                      out_result.version};
    assign m_tuser = out_result.found;

endmodule

// ===== hdl/qrvi_checker.sv =====
// Port-level checker for the QR version-information decoder, with its bind.
module qrvi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // No result may be offered right after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reported version and distance stay in range, padding is zero.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[5:0] >= 6'd7) && (m_tdata[5:0] <= 6'd40)
                     && (m_tdata[10:6] <= 5'd18) && (m_tdata[15:11] == 5'd0))
        else $error("result field out of range");

    // An exact codeword match is always accepted.
    a_exact_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[10:6] == 5'd0) |-> m_tuser)
        else $error("exact match not flagged as found");

endmodule

bind qr_version_info_nearest_decode qrvi_checker u_qrvi_checker (.*);
